>>> rtl/odnm_pkg.sv
package odnm_pkg;

  localparam int W   = 48;
  localparam int F   = 24;
  localparam int H   = W / 2;
  localparam int RB  = (W + F) / 2;
  localparam int UW  = W - 1;
  localparam int NT  = 9;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [UW-1:0] UMAX = {UW{1'b1}};
  localparam logic [UW-1:0] STEP_RESET = UW'(1) << F;
  localparam logic [4:0] DIR_CENTER = 5'd13;
  localparam logic [4:0] DIR_LAST   = 5'd26;
  localparam logic [1:0] AXIS_ZERO  = 2'd1;
  localparam logic [3:0] TERM_LAST  = 4'd8;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_STEP_X = 2'd0;
  localparam cfg_idx_t REG_STEP_Y = 2'd1;
  localparam cfg_idx_t REG_STEP_Z = 2'd2;

  typedef enum logic [1:0] {
    MSEL_AVG_STEP,
    MSEL_T1_STEP,
    MSEL_KAV_LEN
  } msel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_TERM,
    ST_MUL1,
    ST_MUL2,
    ST_CHECK,
    ST_SQRT,
    ST_MUL3,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       dl2_clr;
    logic       mul_start;
    msel_t      msel;
    logic [3:0] term;
    logic       dl2_acc;
    logic       sqrt_start;
    logic       set_bad;
    logic       path_update;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic is_nb;
    logic dir_valid;
    logic last;
    logic term_active;
    logic dl2_pos;
    logic mul_done;
    logic sqrt_done;
    logic out_full;
  } sts_t;

  // metric slot, row and column per quadratic-form term
  localparam logic [2:0] SLOT_TAB [NT] = '{3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd4, 3'd2, 3'd4, 3'd5};
  localparam logic [1:0] ROW_TAB  [NT] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] COL_TAB  [NT] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

  // direction code to {z, y, x} offsets, each stored as offset + 1
  localparam logic [5:0] DIR_TAB [27] = '{
    6'd0,  6'd1,  6'd2,  6'd4,  6'd5,  6'd6,  6'd8,  6'd9,  6'd10,
    6'd16, 6'd17, 6'd18, 6'd20, 6'd21, 6'd22, 6'd24, 6'd25, 6'd26,
    6'd32, 6'd33, 6'd34, 6'd36, 6'd37, 6'd38, 6'd40, 6'd41, 6'd42
  };

endpackage

>>> rtl/odnm_mul.sv
module odnm_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [odnm_pkg::W-1:0]    a,
  input  logic signed [odnm_pkg::W-1:0]    b,
  output logic                             done,
  output logic signed [odnm_pkg::W-1:0]    res
);
  import odnm_pkg::*;

  logic [W-1:0]   ma_r, mb_r;
  logic           neg_r;
  logic [2*W-1:0] acc_r, acc_nxt;
  logic [2:0]     cnt_r;
  logic           busy_r, done_r;
  logic signed [W-1:0] res_r, res_nxt;
  logic [H-1:0]   ha, hb;
  logic [W-1:0]   pp;
  logic [2*W-1:0] pp_sh;
  logic [2*W-F-1:0] q;
  logic [W-1:0]   ma, mb;

  assign ma = a[W-1] ? W'(-a) : W'(a);
  assign mb = b[W-1] ? W'(-b) : W'(b);

  // one half-by-half partial product per cycle
  assign ha = cnt_r[1] ? ma_r[W-1:H] : ma_r[H-1:0];
  assign hb = cnt_r[0] ? mb_r[W-1:H] : mb_r[H-1:0];
  assign pp = ha * hb;

  always_comb begin
    case ({1'b0, cnt_r[1]} + {1'b0, cnt_r[0]})
      2'd0:    pp_sh = (2*W)'(pp);
      2'd1:    pp_sh = (2*W)'(pp) << H;
      default: pp_sh = (2*W)'(pp) << W;
    endcase
  end

  assign acc_nxt = acc_r + pp_sh;
  assign q = acc_r[2*W-1:F];

  always_comb begin
    if (neg_r) begin
      if (q > (2*W-F)'(unsigned'(WMIN))) res_nxt = WMIN;
      else res_nxt = W'(-q);
    end else begin
      if (q > (2*W-F)'(unsigned'(WMAX))) res_nxt = WMAX;
      else res_nxt = W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= ma;
      mb_r  <= mb;
      neg_r <= a[W-1] ^ b[W-1];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == 3'd4) res_r <= res_nxt;
      else acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

>>> rtl/odnm_sqrt.sv
module odnm_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [odnm_pkg::W-1:0]        rad,
  output logic                          done,
  output logic [odnm_pkg::RB-1:0]       root
);
  import odnm_pkg::*;

  localparam int CW = $clog2(RB + 1);

  logic [2*RB-1:0] rad_r;
  logic [RB+1:0]   rem_r;
  logic [RB-1:0]   root_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;
  logic [RB+3:0]   rem_sh, trial;
  logic            ge;

  // one root bit per cycle, restoring
  assign rem_sh = {rem_r, rad_r[2*RB-1 -: 2]};
  assign trial  = (RB+4)'({root_r, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(RB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= (2*RB)'(rad) << F;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? (RB+2)'(rem_sh - trial) : (RB+2)'(rem_sh);
      root_r <= {root_r[RB-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> rtl/odnm_dp.sv
module odnm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  odnm_pkg::cfg_idx_t                  cfg_index,
  input  logic [odnm_pkg::UW-1:0]             cfg_data,
  input  logic                                in_opcode,
  input  logic [4:0]                          in_direction,
  input  logic signed [odnm_pkg::W-1:0]       in_metric_xx,
  input  logic signed [odnm_pkg::W-1:0]       in_metric_xy,
  input  logic signed [odnm_pkg::W-1:0]       in_metric_xz,
  input  logic signed [odnm_pkg::W-1:0]       in_metric_yy,
  input  logic signed [odnm_pkg::W-1:0]       in_metric_yz,
  input  logic signed [odnm_pkg::W-1:0]       in_metric_zz,
  input  logic [odnm_pkg::UW-1:0]             in_opacity,
  input  logic [odnm_pkg::UW-1:0]             in_prior_depth,
  input  logic                                in_last_neighbour,
  input  odnm_pkg::cmd_t                      cmd,
  output odnm_pkg::sts_t                      sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [odnm_pkg::UW-1:0]             out_optical_depth,
  output logic                                out_no_valid_path
);
  import odnm_pkg::*;

  logic [UW-1:0]       step_r [3];
  logic signed [W-1:0] cmet_r [6];
  logic [UW-1:0]       cop_r;
  logic signed [W-1:0] avg_r [6];
  logic [UW-1:0]       kav_r, prior_r;
  logic [5:0]          dcode_r;
  logic                dvalid_r, last_r, is_nb_r;
  logic signed [W-1:0] dl2_r, dl2_nxt;
  logic [UW-1:0]       min_r;
  logic                bad_r, seen_r;
  logic                out_valid_r;
  logic [UW-1:0]       od_r;
  logic                nvp_r;

  logic signed [W-1:0] m_in [6];
  logic [1:0]          ci, cj, row, col;
  logic signed [W-1:0] mul_a, mul_b, mul_res, t_adj;
  logic                mul_done, sqrt_done;
  logic [RB-1:0]       root;
  logic signed [W:0]   sum;
  logic [W-1:0]        psum;
  logic [UW-1:0]       path;

  assign m_in = '{in_metric_xx, in_metric_xy, in_metric_xz,
                  in_metric_yy, in_metric_yz, in_metric_zz};

  assign row = ROW_TAB[cmd.term];
  assign col = COL_TAB[cmd.term];
  assign ci  = dcode_r[2*row +: 2];
  assign cj  = dcode_r[2*col +: 2];

  // the first product of a term is held in the multiplier result register
  always_comb begin
    case (cmd.msel)
      MSEL_AVG_STEP: begin
        mul_a = avg_r[SLOT_TAB[cmd.term]];
        mul_b = W'(step_r[row]);
      end
      MSEL_T1_STEP: begin
        mul_a = mul_res;
        mul_b = W'(step_r[col]);
      end
      MSEL_KAV_LEN: begin
        mul_a = W'(kav_r);
        mul_b = W'(root);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  odnm_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.mul_start),
    .a(mul_a), .b(mul_b), .done(mul_done), .res(mul_res)
  );

  odnm_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start),
    .rad(dl2_r), .done(sqrt_done), .root(root)
  );

  // saturating accumulate of the signed term
  always_comb begin
    if (ci != cj) t_adj = (mul_res == WMIN) ? WMAX : W'(-mul_res);
    else t_adj = mul_res;
    sum = {dl2_r[W-1], dl2_r} + {t_adj[W-1], t_adj};
    if (sum[W] != sum[W-1]) dl2_nxt = sum[W] ? WMIN : WMAX;
    else dl2_nxt = sum[W-1:0];
  end

  assign psum = W'(unsigned'(mul_res)) + W'(prior_r);
  assign path = psum[W-1] ? UMAX : psum[UW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '{STEP_RESET, STEP_RESET, STEP_RESET};
      cmet_r      <= '{default: '0};
      cop_r       <= '0;
      min_r       <= UMAX;
      bad_r       <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      is_nb_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_X: step_r[0] <= cfg_data;
          REG_STEP_Y: step_r[1] <= cfg_data;
          REG_STEP_Z: step_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.capture) begin
        is_nb_r <= in_opcode;
        if (!in_opcode) begin
          cmet_r <= m_in;
          cop_r  <= in_opacity;
          min_r  <= UMAX;
          bad_r  <= 1'b0;
          seen_r <= 1'b0;
        end
      end
      if (cmd.set_bad) bad_r <= 1'b1;
      if (cmd.path_update) begin
        seen_r <= 1'b1;
        if (path < min_r) min_r <= path;
      end
      if (cmd.emit) begin
        min_r  <= UMAX;
        bad_r  <= 1'b0;
        seen_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int k = 0; k < 6; k++) begin
        avg_r[k] <= W'(({cmet_r[k][W-1], cmet_r[k]} + {m_in[k][W-1], m_in[k]}) >>> 1);
      end
      kav_r    <= UW'((W'(cop_r) + W'(in_opacity)) >> 1);
      prior_r  <= in_prior_depth;
      dcode_r  <= (in_direction <= DIR_LAST) ? DIR_TAB[in_direction] : '0;
      dvalid_r <= (in_direction <= DIR_LAST) && (in_direction != DIR_CENTER);
      last_r   <= in_last_neighbour;
    end
    if (cmd.dl2_clr) dl2_r <= '0;
    else if (cmd.dl2_acc) dl2_r <= dl2_nxt;
    if (cmd.emit) begin
      od_r  <= min_r;
      nvp_r <= !seen_r || bad_r;
    end
  end

  assign sts.is_nb       = is_nb_r;
  assign sts.dir_valid   = dvalid_r;
  assign sts.last        = last_r;
  assign sts.term_active = (ci != AXIS_ZERO) && (cj != AXIS_ZERO);
  assign sts.dl2_pos     = !dl2_r[W-1] && (dl2_r != '0);
  assign sts.mul_done    = mul_done;
  assign sts.sqrt_done   = sqrt_done;
  assign sts.out_full    = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_optical_depth = od_r;
  assign out_no_valid_path = nvp_r;

endmodule

>>> rtl/odnm_ctrl.sv
module odnm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  odnm_pkg::sts_t  sts,
  output odnm_pkg::cmd_t  cmd
);
  import odnm_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] term_r, term_nxt;

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        term_nxt = '0;
        if (!sts.is_nb) state_nxt = ST_IDLE;
        else if (sts.dir_valid) state_nxt = ST_TERM;
        else state_nxt = ST_FINISH;
      end
      ST_TERM: begin
        if (sts.term_active) state_nxt = ST_MUL1;
        else if (term_r == TERM_LAST) state_nxt = ST_CHECK;
        else term_nxt = term_r + 4'd1;
      end
      ST_MUL1:   if (sts.mul_done) state_nxt = ST_MUL2;
      ST_MUL2: begin
        if (sts.mul_done) begin
          if (term_r == TERM_LAST) state_nxt = ST_CHECK;
          else begin
            term_nxt  = term_r + 4'd1;
            state_nxt = ST_TERM;
          end
        end
      end
      ST_CHECK:  state_nxt = sts.dl2_pos ? ST_SQRT : ST_FINISH;
      ST_SQRT:   if (sts.sqrt_done) state_nxt = ST_MUL3;
      ST_MUL3:   if (sts.mul_done) state_nxt = ST_FINISH;
      ST_FINISH: if (!sts.last || !sts.out_full) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.term = term_r;
    cmd.msel = MSEL_AVG_STEP;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECIDE: cmd.dl2_clr = 1'b1;
      ST_TERM:   cmd.mul_start = sts.term_active;
      ST_MUL1: begin
        cmd.msel      = MSEL_T1_STEP;
        cmd.mul_start = sts.mul_done;
      end
      ST_MUL2:   cmd.dl2_acc = sts.mul_done;
      ST_CHECK: begin
        cmd.sqrt_start = sts.dl2_pos;
        cmd.set_bad    = !sts.dl2_pos;
      end
      ST_SQRT: begin
        cmd.msel      = MSEL_KAV_LEN;
        cmd.mul_start = sts.sqrt_done;
      end
      ST_MUL3: begin
        cmd.msel        = MSEL_KAV_LEN;
        cmd.path_update = sts.mul_done;
      end
      ST_FINISH: cmd.emit = sts.last && !sts.out_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
    end
  end

endmodule

>>> rtl/optical_depth_neighbour_min_core.sv
// Minimum path optical depth over the neighbors of one cell, Q24.24 fixed point.
// A center beat loads the cell. A neighbor beat steps through the nine metric
// terms, with two multiplies on one shared multiplier per nonzero term (1, 4
// or 9 terms for one, two or three nonzero offsets), then the bit-serial
// square root and the final multiply-add. A nonpositive squared length skips
// the root and the multiply-add. Ignored directions skip all of these. The
// result beat waits in an output register, so a new item is taken while it
// is pending; a last neighbor stalls only while that register is still full.
module optical_depth_neighbour_min_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  odnm_pkg::cfg_idx_t             cfg_index,
  input  logic [odnm_pkg::UW-1:0]        cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [4:0]                     in_direction,
  input  logic signed [odnm_pkg::W-1:0]  in_metric_xx,
  input  logic signed [odnm_pkg::W-1:0]  in_metric_xy,
  input  logic signed [odnm_pkg::W-1:0]  in_metric_xz,
  input  logic signed [odnm_pkg::W-1:0]  in_metric_yy,
  input  logic signed [odnm_pkg::W-1:0]  in_metric_yz,
  input  logic signed [odnm_pkg::W-1:0]  in_metric_zz,
  input  logic [odnm_pkg::UW-1:0]        in_opacity,
  input  logic [odnm_pkg::UW-1:0]        in_prior_depth,
  input  logic                           in_last_neighbour,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [odnm_pkg::UW-1:0]        out_optical_depth,
  output logic                           out_no_valid_path
);
  import odnm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  odnm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  odnm_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_opcode(in_opcode), .in_direction(in_direction),
    .in_metric_xx(in_metric_xx), .in_metric_xy(in_metric_xy),
    .in_metric_xz(in_metric_xz), .in_metric_yy(in_metric_yy),
    .in_metric_yz(in_metric_yz), .in_metric_zz(in_metric_zz),
    .in_opacity(in_opacity), .in_prior_depth(in_prior_depth),
    .in_last_neighbour(in_last_neighbour),
    .cmd(cmd), .sts(sts),
    .out_ready(out_ready), .out_valid(out_valid),
    .out_optical_depth(out_optical_depth), .out_no_valid_path(out_no_valid_path)
  );

endmodule
